>>> rtl/rse_pkg.sv
// Shared constants and types for the RPN stack evaluator.
`timescale 1ns / 1ps

package rse_pkg;

    localparam int DATA_W          = 32;
    localparam int STACK_DEPTH_DEF = 32;

    // token codes
    localparam logic [2:0] CMD_PUSH = 3'd0;
    localparam logic [2:0] CMD_ADD  = 3'd1;
    localparam logic [2:0] CMD_SUB  = 3'd2;
    localparam logic [2:0] CMD_MUL  = 3'd3;
    localparam logic [2:0] CMD_DIV  = 3'd4;

    // status codes
    localparam logic [2:0] STS_OK     = 3'd0;
    localparam logic [2:0] STS_FEW    = 3'd1;
    localparam logic [2:0] STS_DIVZ   = 3'd2;
    localparam logic [2:0] STS_BADTOK = 3'd3;
    localparam logic [2:0] STS_FULL   = 3'd4;
    localparam logic [2:0] STS_EMPTY  = 3'd5;

    localparam logic [3:0] DIGIT_MAX = 4'd9;

    // what a stack cell loads this cycle
    typedef enum logic [1:0] {
        CELL_HOLD      = 2'd0,
        CELL_FROM_UP   = 2'd1,
        CELL_FROM_DOWN = 2'd2
    } cell_op_t;

endpackage

>>> rtl/rse_cell.sv
// One stack cell: holds an operand and shifts toward the top or the bottom.
`timescale 1ns / 1ps

module rse_cell (
    input  logic                      clk,
    input  rse_pkg::cell_op_t         op,
    input  logic [rse_pkg::DATA_W-1:0] up_val,
    input  logic [rse_pkg::DATA_W-1:0] down_val,
    output logic [rse_pkg::DATA_W-1:0] val
);
    import rse_pkg::*;

    logic [DATA_W-1:0] val_reg;
    logic [DATA_W-1:0] val_next;

    always_comb
    begin
        case (op)
            CELL_FROM_UP:   val_next = up_val;
            CELL_FROM_DOWN: val_next = down_val;
            default:        val_next = val_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val = val_reg;

endmodule

>>> rtl/rse_divider.sv
// Iterative signed divider, truncating toward zero, one quotient bit per cycle.
`timescale 1ns / 1ps

module rse_divider (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [rse_pkg::DATA_W-1:0] dividend,
    input  logic [rse_pkg::DATA_W-1:0] divisor,
    output logic                       done,
    output logic [rse_pkg::DATA_W-1:0] quotient
);
    import rse_pkg::*;

    localparam int CNT_W = $clog2(DATA_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             neg_reg;
    logic [DATA_W-1:0] dvd_reg;
    logic [DATA_W-1:0] dvs_reg;
    logic [DATA_W-1:0] rem_reg;

    logic [DATA_W:0]   rem_shift;
    logic [DATA_W:0]   diff;
    logic              qbit;
    logic [DATA_W-1:0] rem_next;
    logic [DATA_W-1:0] mag_a;
    logic [DATA_W-1:0] mag_b;

    assign mag_a     = dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
    assign mag_b     = divisor[DATA_W-1]  ? (~divisor + 1'b1)  : divisor;
    assign rem_shift = {rem_reg, dvd_reg[DATA_W-1]};
    assign diff      = rem_shift - {1'b0, dvs_reg};
    assign qbit      = ~diff[DATA_W];
    assign rem_next  = qbit ? diff[DATA_W-1:0] : rem_shift[DATA_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && !start && (cnt_reg == CNT_W'(DATA_W - 1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DATA_W - 1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // dvd_reg shifts the dividend out and the quotient in
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= mag_a;
            dvs_reg <= mag_b;
            rem_reg <= '0;
            neg_reg <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[DATA_W-2:0], qbit};
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (~dvd_reg + 1'b1) : dvd_reg;

endmodule

>>> rtl/rpn_stack_evaluator.sv
// Top level of the RPN stack evaluator: token decode, stack cell chain, arithmetic.
`timescale 1ns / 1ps

// Takes one token per request and returns one result per token. The operand
// stack is a chain of STACK_DEPTH shift cells with the top in cell 0; a push
// shifts the chain down, an operator writes its result into cell 0 and shifts
// the rest up. One token is in work at a time. A push, a failing token or any
// token after an error goes straight to S_OUT; add, subtract and multiply
// write alu_reg back in S_WB; divide waits in S_DIV for the divider. Once an
// error is flagged it sticks until the token marked last, whose result ends
// the expression and clears the stack and the status.

module rpn_stack_evaluator #(
    parameter int STACK_DEPTH = rse_pkg::STACK_DEPTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [2:0]                 cmd,
    input  logic [3:0]                 digit,
    input  logic                       last,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [rse_pkg::DATA_W-1:0] top_value,
    output logic [2:0]                 status,
    output logic                       done_res
);
    import rse_pkg::*;

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_WB   = 4'b0010,
        S_DIV  = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [2:0]        err_reg, err_next;
    logic              last_reg, last_next;
    logic [DATA_W-1:0] alu_reg, alu_next;

    cell_op_t          top_op;
    cell_op_t          rest_op;
    logic [DATA_W-1:0] top_load;
    logic              div_start;
    logic              div_done;
    logic [DATA_W-1:0] div_quot;

    logic [DATA_W-1:0] cell_val [STACK_DEPTH];
    logic [DATA_W-1:0] opnd_a;
    logic [DATA_W-1:0] opnd_b;

    assign opnd_b = cell_val[0];
    assign opnd_a = cell_val[1];

    genvar gi;
    generate
        for (gi = 0; gi < STACK_DEPTH; gi++)
        begin : g_cell
            logic [DATA_W-1:0] up_v;
            logic [DATA_W-1:0] down_v;
            cell_op_t          op_v;

            if (gi == 0)
            begin : g_top
                assign up_v = top_load;
                assign op_v = top_op;
            end
            else
            begin : g_mid
                assign up_v = cell_val[gi-1];
                assign op_v = rest_op;
            end

            if (gi == STACK_DEPTH - 1)
            begin : g_bot
                assign down_v = '0;
            end
            else
            begin : g_nbot
                assign down_v = cell_val[gi+1];
            end

            rse_cell u_cell (
                .clk      (clk),
                .op       (op_v),
                .up_val   (up_v),
                .down_val (down_v),
                .val      (cell_val[gi])
            );
        end
    endgenerate

    rse_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (opnd_a),
        .divisor  (opnd_b),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        err_next   = err_reg;
        last_next  = last_reg;
        alu_next   = alu_reg;
        top_op     = CELL_HOLD;
        rest_op    = CELL_HOLD;
        top_load   = alu_reg;
        div_start  = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    last_next  = last;
                    state_next = S_OUT;
                    if (err_reg == STS_OK)
                    begin
                        if (cmd == CMD_PUSH)
                        begin
                            if (digit > DIGIT_MAX)
                                err_next = STS_BADTOK;
                            else if (count_reg >= CNT_W'(STACK_DEPTH))
                                err_next = STS_FULL;
                            else
                            begin
                                top_op     = CELL_FROM_UP;
                                rest_op    = CELL_FROM_UP;
                                top_load   = {{(DATA_W-4){1'b0}}, digit};
                                count_next = count_reg + 1'b1;
                            end
                        end
                        else if (cmd == CMD_ADD || cmd == CMD_SUB ||
                                 cmd == CMD_MUL || cmd == CMD_DIV)
                        begin
                            if (count_reg < CNT_W'(2))
                                err_next = STS_FEW;
                            else
                            begin
                                case (cmd)
                                    CMD_ADD:
                                    begin
                                        alu_next   = opnd_a + opnd_b;
                                        state_next = S_WB;
                                    end
                                    CMD_SUB:
                                    begin
                                        alu_next   = opnd_a - opnd_b;
                                        state_next = S_WB;
                                    end
                                    CMD_MUL:
                                    begin
                                        alu_next   = DATA_W'(opnd_a * opnd_b);
                                        state_next = S_WB;
                                    end
                                    default:
                                    begin
                                        if (opnd_b == '0)
                                            err_next = STS_DIVZ;
                                        else
                                        begin
                                            div_start  = 1'b1;
                                            state_next = S_DIV;
                                        end
                                    end
                                endcase
                            end
                        end
                        else
                            err_next = STS_BADTOK;
                    end
                end
            end

            S_WB:
            begin
                top_op     = CELL_FROM_UP;
                rest_op    = CELL_FROM_DOWN;
                top_load   = alu_reg;
                count_next = count_reg - 1'b1;
                state_next = S_OUT;
            end

            S_DIV:
            begin
                if (div_done)
                begin
                    top_op     = CELL_FROM_UP;
                    rest_op    = CELL_FROM_DOWN;
                    top_load   = div_quot;
                    count_next = count_reg - 1'b1;
                    state_next = S_OUT;
                end
            end

            S_OUT:
            begin
                if (out_ready)
                begin
                    if (last_reg)
                    begin
                        count_next = '0;
                        err_next   = STS_OK;
                    end
                    state_next = S_IDLE;
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            err_reg   <= STS_OK;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            err_reg   <= err_next;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        alu_reg <= alu_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign top_value = (count_reg != '0) ? cell_val[0] : '0;
    // an empty stack at the end only reports when nothing failed earlier
    assign status    = (last_reg && err_reg == STS_OK && count_reg == '0) ?
                       STS_EMPTY : err_reg;
    assign done_res  = last_reg;

endmodule
